// ----- rtl/sliding_window_maximum_defines.svh -----
// Assertion macros shared by the sliding window maximum RTL.
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swm_pkg.sv -----
// Types, constants and register map of the sliding window maximum block.
`default_nettype none

package swm_pkg;

    localparam int unsigned SAMPLE_WIDTH       = 16;
    localparam int unsigned AGE_WIDTH          = 7;
    localparam int unsigned WSIZE_WIDTH        = 7;
    localparam int unsigned WINDOW_MAX_DEFAULT = 64;

    localparam logic [AGE_WIDTH-1:0]   AGE_LIMIT         = 7'd127;
    localparam logic [WSIZE_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd1;

    // APB register map: one 32-bit register, word index taken from paddr[2]
    localparam int unsigned APB_ADDR_WIDTH = 3;
    localparam int unsigned APB_DATA_WIDTH = 32;
    localparam logic        REG_WINDOW_SIZE = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           first_of_sequence;
        logic                           last_of_sequence;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] window_max;
        logic                           last_result;
    } result_t;

    // One queue entry as seen by a slot and its neighbors
    typedef struct packed {
        logic                           valid;
        logic [AGE_WIDTH-1:0]           age;
        logic signed [SAMPLE_WIDTH-1:0] value;
    } swm_entry_t;

    // Broadcast control to every slot of the chain
    typedef struct packed {
        logic                           step;
        logic                           clear;
        logic                           shift;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } swm_ctl_t;

    typedef enum logic {
        SWM_IDLE,
        SWM_EXPIRE
    } swm_state_t;

endpackage

`default_nettype wire

// ----- rtl/sliding_window_maximum.sv -----
// Top level of the streaming sliding window maximum with APB configuration.
//
// Usage:
//   Samples enter on the item channel (item_valid/item_ready, payload item).
//   Window maxima leave on the result channel (result_valid/result_ready,
//   payload result). Each beat carries one sample; a beat gives a result once
//   window_size samples of the current sequence have arrived, otherwise none.
//   first_of_sequence empties the queue; last_of_sequence comes back as
//   last_result. The user writes window_size (APB byte address 0) only while
//   idle (not enforced); 0 turns results off, values above WINDOW_MAX clamp.
// Timing:
//   A sample's result, if any, is registered in the output register. If more
//   than one candidate must leave the front, the block stays in EXPIRE until
//   they have left, which only happens after window_size has been lowered.
//   The WINDOW_MAX slots all age, compare and shift in the same cycle, so a
//   steady stream runs at one sample per clock, barring EXPIRE or output stalls.
// Reset and stall:
//   Reset empties the queue, clears the sample count and sets window_size to
//   1; no clearing pass is needed. While a result waits for result_ready, a
//   new sample is taken only in the cycle that the waiting result leaves.
`default_nettype none

module sliding_window_maximum #(
    parameter int unsigned WINDOW_MAX = swm_pkg::WINDOW_MAX_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_ready,
    input  wire swm_pkg::item_t                       item,
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output swm_pkg::result_t                          result,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [swm_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [swm_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [swm_pkg::APB_DATA_WIDTH-1:0]        prdata,
    output logic                                      pready
);

`include "sliding_window_maximum_defines.svh"

    localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
    localparam int unsigned EW = (CW > swm_pkg::WSIZE_WIDTH) ? CW : swm_pkg::WSIZE_WIDTH;

    swm_pkg::swm_state_t                 state_reg;
    swm_pkg::swm_state_t                 state_next;
    logic [swm_pkg::WSIZE_WIDTH-1:0]     window_size_reg;
    logic [swm_pkg::WSIZE_WIDTH-1:0]     window_size_next;
    logic [CW-1:0]                       filled_reg;
    logic [CW-1:0]                       filled_next;
    logic                                pend_emit_reg;
    logic                                pend_emit_next;
    logic                                pend_last_reg;
    logic                                pend_last_next;
    logic                                result_valid_reg;
    logic                                result_valid_next;
    swm_pkg::result_t                    result_reg;
    swm_pkg::result_t                    result_next;

    logic                                cfg_write;
    logic                                accept;
    logic                                active;
    logic [EW-1:0]                       ws_ext;
    logic [EW-1:0]                       w_eff;
    logic [EW-1:0]                       w_min1;
    logic                                emit_now;
    logic                                emit_flag;
    logic                                last_flag;
    logic                                shift;
    logic                                still_expired;
    logic                                out_free;
    logic                                finish;
    logic                                load_result;
    swm_pkg::swm_entry_t                 head_next;
    swm_pkg::swm_ctl_t                   ctl;
    swm_pkg::swm_entry_t                 virt_arr [0:WINDOW_MAX];
    logic                                keep_arr [0:WINDOW_MAX];
    logic [WINDOW_MAX-1:0]               occ_vec;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW_SIZE);
    assign window_size_next = cfg_write ? pwdata[swm_pkg::WSIZE_WIDTH-1:0] : window_size_reg;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == swm_pkg::REG_WINDOW_SIZE)
        begin
            prdata[swm_pkg::WSIZE_WIDTH-1:0] = window_size_reg;
        end
    end

    // ---------------- window size and fill count ----------------
    assign ws_ext = EW'(window_size_reg);
    assign w_eff  = (ws_ext > EW'(WINDOW_MAX)) ? EW'(WINDOW_MAX) : ws_ext;
    // the freshly appended sample (age 0) never leaves in the same beat
    assign w_min1 = (w_eff == '0) ? EW'(1) : w_eff;

    assign accept = item_valid && item_ready;
    assign active = accept || (state_reg == swm_pkg::SWM_EXPIRE);

    always_comb
    begin
        filled_next = filled_reg;
        if (accept)
        begin
            if (item.first_of_sequence)
            begin
                filled_next = CW'(1);
            end
            else if (filled_reg < CW'(WINDOW_MAX))
            begin
                filled_next = filled_reg + 1'b1;
            end
        end
    end

    assign emit_now  = (w_eff != '0) && (EW'(filled_next) >= w_eff);
    assign emit_flag = accept ? emit_now : pend_emit_reg;
    assign last_flag = accept ? item.last_of_sequence : pend_last_reg;
    assign pend_emit_next = emit_flag;
    assign pend_last_next = last_flag;

    // ---------------- slot chain ----------------
    assign shift = active && virt_arr[0].valid && (EW'(virt_arr[0].age) >= w_min1);

    assign ctl.step   = accept;
    assign ctl.clear  = item.first_of_sequence;
    assign ctl.shift  = shift;
    assign ctl.sample = item.sample;

    assign keep_arr[0] = 1'b1;

    // virtual slot behind the chain catches the sample when every slot keeps
    assign virt_arr[WINDOW_MAX].valid = accept && keep_arr[WINDOW_MAX];
    assign virt_arr[WINDOW_MAX].age   = '0;
    assign virt_arr[WINDOW_MAX].value = item.sample;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_slot
        swm_slot u_slot (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .left_keep  (keep_arr[i]),
            .right_virt (virt_arr[i+1]),
            .virt       (virt_arr[i]),
            .keep       (keep_arr[i+1]),
            .occ        (occ_vec[i])
        );
    end

    assign head_next     = shift ? virt_arr[1] : virt_arr[0];
    assign still_expired = head_next.valid && (EW'(head_next.age) >= w_min1);
    assign out_free      = !result_valid_reg || result_ready;
    assign finish        = active && !still_expired && (!emit_flag || out_free);

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swm_pkg::SWM_IDLE:
            begin
                if (accept && !finish)
                begin
                    state_next = swm_pkg::SWM_EXPIRE;
                end
            end
            swm_pkg::SWM_EXPIRE:
            begin
                if (finish)
                begin
                    state_next = swm_pkg::SWM_IDLE;
                end
            end
            default:
            begin
                state_next = swm_pkg::SWM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            swm_pkg::SWM_IDLE:   item_ready = out_free;
            swm_pkg::SWM_EXPIRE: item_ready = 1'b0;
            default:             item_ready = 1'b0;
        endcase
        load_result = finish && emit_flag;
    end

    // ---------------- result register ----------------
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (load_result)
        begin
            result_valid_next       = 1'b1;
            result_next.window_max  = head_next.value;
            result_next.last_result = last_flag;
        end
        else if (result_ready)
        begin
            // drop the beat once taken
            result_valid_next = 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= swm_pkg::SWM_IDLE;
            window_size_reg  <= swm_pkg::WINDOW_SIZE_RESET;
            filled_reg       <= '0;
            pend_emit_reg    <= 1'b0;
            pend_last_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_size_reg  <= window_size_next;
            filled_reg       <= filled_next;
            pend_emit_reg    <= pend_emit_next;
            pend_last_reg    <= pend_last_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // ---------------- assertions ----------------
    `SWM_ASSERT_NOW(a_occ_prefix, 1'b1,
        ((occ_vec & (occ_vec + {{(WINDOW_MAX-1){1'b0}}, 1'b1})) == '0),
        "occupied slots do not form a prefix")
    `SWM_ASSERT_NOW(a_expire_nonempty, (state_reg == swm_pkg::SWM_EXPIRE), occ_vec[0],
        "queue empty while candidates are being retired")
    `SWM_ASSERT_NEXT(a_first_restarts, (accept && item.first_of_sequence),
        (filled_reg == CW'(1)), "first sample did not restart the count")
    `SWM_ASSERT_NOW(a_fill_bound, 1'b1, (filled_reg <= CW'(WINDOW_MAX)),
        "fill count beyond the slot count")

endmodule

`default_nettype wire

// ----- rtl/swm_slot.sv -----
// One slot of the candidate queue: holds an entry and hands it to its left neighbor.
`default_nettype none

module swm_slot (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire swm_pkg::swm_ctl_t    ctl,
    input  wire logic                 left_keep,
    input  wire swm_pkg::swm_entry_t  right_virt,
    output swm_pkg::swm_entry_t       virt,
    output logic                      keep,
    output logic                      occ
);

    logic                                    valid_reg;
    logic                                    valid_next;
    logic [swm_pkg::AGE_WIDTH-1:0]           age_reg;
    logic [swm_pkg::AGE_WIDTH-1:0]           age_next;
    logic signed [swm_pkg::SAMPLE_WIDTH-1:0] value_reg;
    logic signed [swm_pkg::SAMPLE_WIDTH-1:0] value_next;
    logic                                    cur_valid;
    logic                                    smaller;
    logic [swm_pkg::AGE_WIDTH-1:0]           age_inc;
    swm_pkg::swm_entry_t                     entry_next;

    assign cur_valid = valid_reg && !(ctl.step && ctl.clear);
    assign smaller   = $signed(value_reg) < $signed(ctl.sample);
    assign keep      = cur_valid && !(ctl.step && smaller);
    assign age_inc   = (age_reg == swm_pkg::AGE_LIMIT) ? age_reg : age_reg + 1'b1;
    assign occ       = valid_reg;

    // View of this slot after aging, dropping smaller entries and appending
    always_comb
    begin
        if (ctl.step)
        begin
            if (keep)
            begin
                virt.valid = 1'b1;
                virt.age   = age_inc;
                virt.value = value_reg;
            end
            else
            begin
                // first free slot behind the kept prefix takes the new sample
                virt.valid = left_keep;
                virt.age   = '0;
                virt.value = ctl.sample;
            end
        end
        else
        begin
            virt.valid = valid_reg;
            virt.age   = age_reg;
            virt.value = value_reg;
        end
    end

    // Advance toward the front when the head expires
    assign entry_next = ctl.shift ? right_virt : virt;
    assign valid_next = entry_next.valid;
    assign age_next   = entry_next.age;
    assign value_next = entry_next.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire
